[hdl/bdlc_pkg.sv]
// Shared types and constants for the base-delta line classifier.
// Depends on nothing; every other file in the block imports it.
package bdlc_pkg;

    localparam int LINE_BITS  = 256;
    localparam int ENC_W      = 4;
    localparam int BYTES_W    = 6;
    localparam int OUT_TDATA_W = 16;

    localparam logic [ENC_W-1:0] ENC_ZEROS  = 4'd0;
    localparam logic [ENC_W-1:0] ENC_REPEAT = 4'd1;
    localparam logic [ENC_W-1:0] ENC_B8D1   = 4'd2;
    localparam logic [ENC_W-1:0] ENC_B4D1   = 4'd3;
    localparam logic [ENC_W-1:0] ENC_B8D2   = 4'd4;
    localparam logic [ENC_W-1:0] ENC_B2D1   = 4'd5;
    localparam logic [ENC_W-1:0] ENC_B4D2   = 4'd6;
    localparam logic [ENC_W-1:0] ENC_B8D4   = 4'd7;
    localparam logic [ENC_W-1:0] ENC_NONE   = 4'd8;

    localparam logic [BYTES_W-1:0] SIZE_ZEROS  = 6'd1;
    localparam logic [BYTES_W-1:0] SIZE_REPEAT = 6'd8;
    localparam logic [BYTES_W-1:0] SIZE_B8D1   = 6'd12;
    localparam logic [BYTES_W-1:0] SIZE_B4D1   = 6'd12;
    localparam logic [BYTES_W-1:0] SIZE_B8D2   = 6'd16;
    localparam logic [BYTES_W-1:0] SIZE_B2D1   = 6'd18;
    localparam logic [BYTES_W-1:0] SIZE_B4D2   = 6'd20;
    localparam logic [BYTES_W-1:0] SIZE_B8D4   = 6'd24;
    localparam logic [BYTES_W-1:0] SIZE_NONE   = 6'd32;

    typedef struct packed {
        logic [ENC_W-1:0]   encoding;
        logic [BYTES_W-1:0] compressed_bytes;
    } result_t;

    function automatic logic [BYTES_W-1:0] enc_size(input logic [ENC_W-1:0] enc);
        logic [BYTES_W-1:0] size;
        case (enc)
            ENC_ZEROS:  size = SIZE_ZEROS;
            ENC_REPEAT: size = SIZE_REPEAT;
            ENC_B8D1:   size = SIZE_B8D1;
            ENC_B4D1:   size = SIZE_B4D1;
            ENC_B8D2:   size = SIZE_B8D2;
            ENC_B2D1:   size = SIZE_B2D1;
            ENC_B4D2:   size = SIZE_B4D2;
            ENC_B8D4:   size = SIZE_B8D4;
            default:    size = SIZE_NONE;
        endcase
        return size;
    endfunction

endpackage

[hdl/bdlc_classify.sv]
// Combinational classifier: all base+delta checks in parallel, then a priority pick.
// Depends on bdlc_pkg.
module bdlc_classify
    import bdlc_pkg::*;
(
    input  logic [LINE_BITS-1:0] line,
    output result_t              result
);

    // Per-element fit flags; element 0 is the base and always fits.
    logic [3:0]  b8_d1;
    logic [3:0]  b8_d2;
    logic [3:0]  b8_d4;
    logic [7:0]  b4_d1;
    logic [7:0]  b4_d2;
    logic [15:0] b2_d1;
    logic        all_zero;
    logic        all_same;
    logic [ENC_W-1:0] enc;

    assign b8_d1[0] = 1'b1;
    assign b8_d2[0] = 1'b1;
    assign b8_d4[0] = 1'b1;
    assign b4_d1[0] = 1'b1;
    assign b4_d2[0] = 1'b1;
    assign b2_d1[0] = 1'b1;

    genvar i;
    generate
        for (i = 1; i < 4; i++) begin : g_b8
            logic [63:0] d;
            assign d = line[i*64 +: 64] - line[63:0];
            // A delta fits when every bit above its sign bit copies the sign.
            assign b8_d1[i] = (&d[63:7])  | ~(|d[63:7]);
            assign b8_d2[i] = (&d[63:15]) | ~(|d[63:15]);
            assign b8_d4[i] = (&d[63:31]) | ~(|d[63:31]);
        end
        for (i = 1; i < 8; i++) begin : g_b4
            logic [32:0] d;
            // Zero-extended elements: one extra bit holds the full signed difference of two 32-bit elements.
            assign d = {1'b0, line[i*32 +: 32]} - {1'b0, line[31:0]};
            assign b4_d1[i] = (&d[32:7])  | ~(|d[32:7]);
            assign b4_d2[i] = (&d[32:15]) | ~(|d[32:15]);
        end
        for (i = 1; i < 16; i++) begin : g_b2
            logic [16:0] d;
            assign d = {1'b0, line[i*16 +: 16]} - {1'b0, line[15:0]};
            assign b2_d1[i] = (&d[16:7]) | ~(|d[16:7]);
        end
    endgenerate

    assign all_zero = ~(|line);
    assign all_same = (line[127:64] == line[63:0]) && (line[191:128] == line[63:0])
                   && (line[255:192] == line[63:0]);

    always_comb
    begin
        if (all_zero)
            enc = ENC_ZEROS;
        else if (all_same)
            enc = ENC_REPEAT;
        else if (&b8_d1)
            enc = ENC_B8D1;
        else if (&b4_d1)
            enc = ENC_B4D1;
        else if (&b8_d2)
            enc = ENC_B8D2;
        else if (&b2_d1)
            enc = ENC_B2D1;
        else if (&b4_d2)
            enc = ENC_B4D2;
        else if (&b8_d4)
            enc = ENC_B8D4;
        else
            enc = ENC_NONE;
    end

    assign result.encoding         = enc;
    assign result.compressed_bytes = enc_size(enc);

endmodule

[hdl/base_delta_line_classifier.sv]
// Top level of the base-delta line classifier: input register, classifier, result register.
// Depends on bdlc_pkg and bdlc_classify.
//
// Usage:
//   The slave channel (s_tvalid, s_tready, s_tdata) takes one 32-byte cache line per
//   request, four 64-bit little-endian words with word 0 in the lowest bits.
//   The master channel (m_tvalid, m_tready, m_tdata) returns one result per line:
//   the chosen encoding and the compressed size in bytes.
//   An accepted request passes the input register, then the result register, before its
//   result is valid. Throughput is one line per cycle while the receiver is ready: the
//   input register and the result register form a two-stage pipeline, and the classifier
//   between them is one pass of parallel subtract-and-compare lanes.
//   When the receiver stalls, the result holds on m_tdata and the line behind it
//   waits in the input register; s_tready drops only once both stages are full.
//   Reset empties both stages; no request in flight survives it.
module base_delta_line_classifier
    import bdlc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // line_word0 [63:0], line_word1 [127:64], line_word2 [191:128], line_word3 [255:192]
    input  logic [LINE_BITS-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // encoding [3:0], compressed_bytes [9:4], zero fill [15:10]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [LINE_BITS-1:0] line_reg;
    logic                 in_valid_reg;
    logic                 in_valid_next;
    result_t              res_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    result_t              res_next;
    logic                 advance;

    bdlc_classify u_classify (
        .line   (line_reg),
        .result (res_next)
    );

    assign advance  = ~out_valid_reg | m_tready;
    assign s_tready = ~in_valid_reg | advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
            in_valid_next = s_tvalid;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            line_reg <= s_tdata;
        if (advance && in_valid_reg)
            res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - ENC_W - BYTES_W){1'b0}},
                       res_reg.compressed_bytes, res_reg.encoding};

endmodule

[hdl/bdlc_checker.sv]
// Port-level checker for the base-delta line classifier, attached by bind.
// Depends on bdlc_pkg and on the ports of base_delta_line_classifier.
module bdlc_checker
    import bdlc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [LINE_BITS-1:0]   s_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // A stalled result holds its value until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or vanished");

    // The size always belongs to the reported encoding.
    a_size: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[9:4] == enc_size(m_tdata[3:0])) && (m_tdata[3:0] <= ENC_NONE))
        else $error("compressed size does not match encoding");

    // Input backpressure only appears when both stages are full and stalled.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a full pipeline");

    // An all-zero line accepted while the receiver stays ready comes out as zeros.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && m_tready && (s_tdata == '0)) ##1 m_tready
        |=> m_tvalid && (m_tdata[3:0] == ENC_ZEROS))
        else $error("all-zero line not reported as zeros");

endmodule

bind base_delta_line_classifier bdlc_checker u_bdlc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
